// File: rtl/ipc_pkg.sv
// Shared types, codes and constants of the ingress packet classifier.
package ipc_pkg;

   localparam int LINKS_DEF   = 4;
   localparam int ENTRIES_DEF = 8;

   localparam int LINK_ID_W = 2;
   localparam int KIND_W    = 3;
   localparam int IFACE_W   = 3;

   localparam logic [KIND_W-1:0] KIND_ADDED  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FULL   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_WORKER = 3'd2;
   localparam logic [KIND_W-1:0] KIND_IFACE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_BCAST  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_DROP   = 3'd5;

   localparam logic REQ_ADD      = 1'b0;
   localparam logic REQ_CLASSIFY = 1'b1;

   localparam logic [15:0] ETH_IPV4     = 16'h0800;
   localparam logic [15:0] ETH_ARP      = 16'h0806;
   localparam logic [7:0]  PROTO_UDP    = 8'd17;
   localparam logic [7:0]  ARP_OP_REPLY = 8'h02;
   localparam logic [31:0] BCAST_IP     = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0] ip;
      logic [15:0] port;
   } tbl_entry_type;

   typedef struct packed {
      logic hit;
      logic worker;
   } cmp_res_type;

endpackage

// File: rtl/ipc_table.sv
// Address table memory: one write port and one registered read port.
module ipc_table import ipc_pkg::*; #(
   parameter int DEPTH  = LINKS_DEF * ENTRIES_DEF,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  tbl_entry_type     wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output tbl_entry_type     rd_data
);

   tbl_entry_type mem [DEPTH];
   tbl_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ipc_cmp.sv
// Compare unit: one table entry against the packet's address and port.
module ipc_cmp import ipc_pkg::*; (
   input  tbl_entry_type entry,
   input  logic [31:0]   dest_ip,
   input  logic          is_udp,
   input  logic [15:0]   udp_port,
   output cmp_res_type   res
);

   always_comb begin
      res.hit    = (entry.ip == dest_ip);
      res.worker = is_udp && (entry.port == udp_port);
   end

endmodule

// File: rtl/ingress_packet_classifier.sv
// Top level: sequencer, per-link entry counts and the result register.
// Add, out-of-range link and empty-table broadcast requests: result sent from the response state.
// Unicast search: one table entry per cycle, until a hit or the end of the link's table.
// Broadcast: one copy per cycle while the result side keeps taking beats.
// One item at a time; the next request beat is taken once the last result is registered.
// Synchronous reset empties every link's table; table contents themselves are not cleared.
module ingress_packet_classifier import ipc_pkg::*; #(
   parameter int LINKS            = LINKS_DEF,
   parameter int ENTRIES_PER_LINK = ENTRIES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_type,
   input  logic [LINK_ID_W-1:0] req_link_id,
   input  logic [31:0]          req_entry_ip,
   input  logic [15:0]          req_entry_port,
   input  logic [15:0]          req_ether_type,
   input  logic [31:0]          req_dest_ip,
   input  logic [7:0]           req_ip_proto,
   input  logic [15:0]          req_udp_dest_port,
   input  logic [7:0]           req_arp_op_low,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [KIND_W-1:0]    rsp_kind,
   output logic [IFACE_W-1:0]   rsp_iface_index,
   output logic                 rsp_arp_reply,
   output logic                 rsp_last
);

   localparam int Depth    = LINKS * ENTRIES_PER_LINK;
   localparam int LinkIdxW = (LINKS > 1) ? $clog2(LINKS) : 1;
   localparam int CntW     = $clog2(ENTRIES_PER_LINK + 1);
   localparam int AddrW    = (Depth > 1) ? $clog2(Depth) : 1;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SRCH  = 2'd1;
   localparam logic [1:0] S_BCAST = 2'd2;
   localparam logic [1:0] S_RESP  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CntW-1:0]     count_ff [LINKS];
   logic [CntW-1:0]     count_in [LINKS];
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic [CntW-1:0]     iss_ff, iss_in;
   logic [CntW-1:0]     pend_idx_ff, pend_idx_in;
   logic                pend_ff, pend_in;
   logic [AddrW-1:0]    base_ff, base_in;
   logic                arp_ff, arp_in;
   logic                udp_ff, udp_in;
   logic [15:0]         uport_ff, uport_in;
   logic [31:0]         dip_ff, dip_in;
   logic [KIND_W-1:0]   res_kind_ff, res_kind_in;
   logic [IFACE_W-1:0]  res_idx_ff, res_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [IFACE_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic                rsp_arp_ff, rsp_arp_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                accept;
   logic                out_free;
   logic                link_ok;
   logic [LinkIdxW-1:0] link_idx;
   logic [CntW-1:0]     cnt_sel;
   logic [AddrW-1:0]    base_calc;
   logic                is_bcast;
   logic                wr_en;
   logic [AddrW-1:0]    wr_addr;
   logic [AddrW-1:0]    rd_addr;
   tbl_entry_type       wr_data;
   tbl_entry_type       rd_data;
   cmp_res_type         cmp_res;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign link_ok   = (32'(req_link_id) < LINKS);
   assign link_idx  = LinkIdxW'(req_link_id);
   assign cnt_sel   = count_ff[link_idx];
   assign base_calc = AddrW'(32'(req_link_id) * ENTRIES_PER_LINK);
   assign is_bcast  = (req_ether_type != ETH_IPV4) || (req_dest_ip == BCAST_IP);

   assign wr_en        = accept && (req_type == REQ_ADD) && link_ok &&
                         (cnt_sel < CntW'(ENTRIES_PER_LINK));
   assign wr_addr      = base_calc + AddrW'(cnt_sel);
   assign wr_data.ip   = req_entry_ip;
   assign wr_data.port = req_entry_port;
   assign rd_addr      = base_ff + AddrW'(iss_ff);

   ipc_table #(
      .DEPTH  (Depth),
      .ADDR_W (AddrW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ipc_cmp u_cmp (
      .entry    (rd_data),
      .dest_ip  (dip_ff),
      .is_udp   (udp_ff),
      .udp_port (uport_ff),
      .res      (cmp_res)
   );

   always_comb begin
      for (int l = 0; l < LINKS; l++) begin
         count_in[l] = count_ff[l];
      end
      if (wr_en) begin
         count_in[link_idx] = cnt_sel + CntW'(1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      iss_in       = iss_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      base_in      = base_ff;
      arp_in       = arp_ff;
      udp_in       = udp_ff;
      uport_in     = uport_ff;
      dip_in       = dip_ff;
      res_kind_in  = res_kind_ff;
      res_idx_in   = res_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_arp_in   = rsp_arp_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cnt_in      = cnt_sel;
               iss_in      = '0;
               pend_in     = 1'b0;
               base_in     = base_calc;
               arp_in      = (req_ether_type == ETH_ARP) && (req_arp_op_low == ARP_OP_REPLY);
               udp_in      = (req_ip_proto == PROTO_UDP);
               uport_in    = req_udp_dest_port;
               dip_in      = req_dest_ip;
               res_idx_in  = '0;
               state_in    = S_RESP;
               if (req_type == REQ_ADD) begin
                  if (wr_en) begin
                     res_kind_in = KIND_ADDED;
                     res_idx_in  = IFACE_W'(cnt_sel);
                  end else begin
                     res_kind_in = KIND_FULL;
                  end
               end else begin
                  res_kind_in = KIND_DROP;
                  if (link_ok && is_bcast && (cnt_sel != '0)) begin
                     state_in = S_BCAST;
                  end else if (link_ok && !is_bcast) begin
                     state_in = S_SRCH;
                  end
               end
            end
         end
         S_SRCH: begin
            // Read data in this cycle belongs to the entry issued in the cycle before.
            if (pend_ff && cmp_res.hit) begin
               res_kind_in = cmp_res.worker ? KIND_WORKER : KIND_IFACE;
               res_idx_in  = IFACE_W'(pend_idx_ff);
               state_in    = S_RESP;
            end else if (iss_ff == cnt_ff) begin
               res_kind_in = KIND_DROP;
               res_idx_in  = '0;
               state_in    = S_RESP;
            end else begin
               pend_in     = 1'b1;
               pend_idx_in = iss_ff;
               iss_in      = iss_ff + CntW'(1);
            end
         end
         S_BCAST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_BCAST;
               rsp_idx_in   = IFACE_W'(iss_ff);
               rsp_arp_in   = arp_ff;
               rsp_last_in  = (iss_ff + CntW'(1) == cnt_ff);
               iss_in       = iss_ff + CntW'(1);
               if (iss_ff + CntW'(1) == cnt_ff) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_idx_in   = res_idx_ff;
               rsp_arp_in   = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         for (int l = 0; l < LINKS; l++) begin
            count_ff[l] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         for (int l = 0; l < LINKS; l++) begin
            count_ff[l] <= count_in[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      iss_ff      <= iss_in;
      pend_idx_ff <= pend_idx_in;
      base_ff     <= base_in;
      arp_ff      <= arp_in;
      udp_ff      <= udp_in;
      uport_ff    <= uport_in;
      dip_ff      <= dip_in;
      res_kind_ff <= res_kind_in;
      res_idx_ff  <= res_idx_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_arp_ff  <= rsp_arp_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_iface_index = rsp_idx_ff;
   assign rsp_arp_reply   = rsp_arp_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTHESIS
   a_srch_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH) |-> (iss_ff <= cnt_ff))
      else $error("search issue counter ran past the entry count");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind != KIND_BCAST)) |-> rsp_last)
      else $error("single-result answer not marked last");

   a_arp_bcast: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_arp_reply) |-> (rsp_kind == KIND_BCAST))
      else $error("ARP reply flag on a non-broadcast result");

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous item still in progress");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind <= KIND_DROP))
      else $error("result kind out of range");
`endif

endmodule

// File: bench/ipc_result_checker.sv
// Checker for the ingress packet classifier: tracks the link tables and compares result beats.
`timescale 1ns / 100ps

module ipc_result_checker import ipc_pkg::*; #(
   parameter int LINKS            = LINKS_DEF,
   parameter int ENTRIES_PER_LINK = ENTRIES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic                 req_type,
   input  logic [LINK_ID_W-1:0] req_link_id,
   input  logic [31:0]          req_entry_ip,
   input  logic [15:0]          req_entry_port,
   input  logic [15:0]          req_ether_type,
   input  logic [31:0]          req_dest_ip,
   input  logic [7:0]           req_ip_proto,
   input  logic [15:0]          req_udp_dest_port,
   input  logic [7:0]           req_arp_op_low,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [KIND_W-1:0]    rsp_kind,
   input  logic [IFACE_W-1:0]   rsp_iface_index,
   input  logic                 rsp_arp_reply,
   input  logic                 rsp_last,
   output int                   fail_count,
   output int                   outstanding,
   output int                   beats_checked
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [IFACE_W-1:0] iface;
      logic               arp;
      logic               last;
   } answer_type;

   logic [31:0] local_ip   [LINKS][ENTRIES_PER_LINK];
   logic [15:0] local_port [LINKS][ENTRIES_PER_LINK];
   int          fill       [LINKS];

   answer_type awaited_answers[$];
   int         n_fail;
   int         n_beats;

   function automatic answer_type make_answer(input logic [KIND_W-1:0] kind, input int idx,
                                              input logic arp, input logic last);
      answer_type a;
      a.kind  = kind;
      a.iface = IFACE_W'(idx);
      a.arp   = arp;
      a.last  = last;
      return a;
   endfunction

   // Works out every result beat that the request beat now on the port will cause.
   task automatic predict_answers();
      int  link;
      int  cnt;
      int  hit;
      logic arp;
      link = int'(req_link_id);
      if (req_type == REQ_ADD) begin
         if (link >= LINKS || fill[link] >= ENTRIES_PER_LINK) begin
            awaited_answers.push_back(make_answer(KIND_FULL, 0, 1'b0, 1'b1));
         end else begin
            local_ip[link][fill[link]]   = req_entry_ip;
            local_port[link][fill[link]] = req_entry_port;
            awaited_answers.push_back(make_answer(KIND_ADDED, fill[link], 1'b0, 1'b1));
            fill[link]++;
         end
      end else if (link >= LINKS) begin
         awaited_answers.push_back(make_answer(KIND_DROP, 0, 1'b0, 1'b1));
      end else if (req_ether_type != ETH_IPV4 || req_dest_ip == BCAST_IP) begin
         cnt = fill[link];
         arp = (req_ether_type == ETH_ARP) && (req_arp_op_low == ARP_OP_REPLY);
         if (cnt == 0)
            awaited_answers.push_back(make_answer(KIND_DROP, 0, 1'b0, 1'b1));
         for (int i = 0; i < cnt; i++)
            awaited_answers.push_back(make_answer(KIND_BCAST, i, arp, i == cnt - 1));
      end else begin
         hit = -1;
         for (int i = 0; i < fill[link]; i++) begin
            if (hit < 0 && local_ip[link][i] == req_dest_ip)
               hit = i;
         end
         if (hit < 0)
            awaited_answers.push_back(make_answer(KIND_DROP, 0, 1'b0, 1'b1));
         else if (req_ip_proto == PROTO_UDP && req_udp_dest_port == local_port[link][hit])
            awaited_answers.push_back(make_answer(KIND_WORKER, hit, 1'b0, 1'b1));
         else
            awaited_answers.push_back(make_answer(KIND_IFACE, hit, 1'b0, 1'b1));
      end
   endtask

   always @(posedge clock) begin : watch
      answer_type want;
      answer_type seen;
      if (reset) begin
         awaited_answers.delete();
         for (int l = 0; l < LINKS; l++)
            fill[l] = 0;
         n_fail  = 0;
         n_beats = 0;
      end else begin
         // Results are retired before the new request is predicted, so a result beat in the
         // same cycle as a request beat is never matched against that request.
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_kind, rsp_iface_index, rsp_arp_reply, rsp_last};
            n_beats++;
            if (awaited_answers.size() == 0) begin
               n_fail++;
               if (n_fail <= REPORT_LIMIT)
                  $display("%0t: result beat with nothing awaited: %s=%0d iface=%0d %s=%0d",
                           $realtime, "kind", seen.kind, seen.iface, "arp", seen.arp);
            end else begin
               want = awaited_answers.pop_front();
               if (seen !== want) begin
                  n_fail++;
                  if (n_fail <= REPORT_LIMIT)
                     $display("%0t: mismatch: expected kind=%0d iface=%0d arp=%0d last=%0d,",
                              $realtime, want.kind, want.iface, want.arp, want.last,
                              " got kind=%0d iface=%0d arp=%0d last=%0d",
                              seen.kind, seen.iface, seen.arp, seen.last);
               end
            end
         end
         if (req_valid && req_ready)
            predict_answers();
      end
      fail_count    <= n_fail;
      outstanding   <= awaited_answers.size();
      beats_checked <= n_beats;
   end

endmodule

// File: bench/tb_ingress_packet_classifier.sv
// Testbench top for the ingress packet classifier: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_ingress_packet_classifier;
   import ipc_pkg::*;

   localparam int RANDOM_ITEMS   = 240;
   localparam int HOLD_AT        = 80;
   localparam int HOLD_CYCLES    = 150;
   localparam int STEADY_LO      = 140;
   localparam int STEADY_HI      = 180;
   localparam int DRAIN_CYCLES   = 2 * (ENTRIES_DEF + 2);
   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic [31:0] IP_POOL_BASE   = 32'h0A00_0001;
   localparam logic [15:0] PORT_POOL_BASE = 16'd4000;
   localparam logic [15:0] TUNNEL_PORT    = 16'd4789;
   localparam logic [31:0] SUBNET_HOST    = 32'hC0A8_0001;
   localparam logic [15:0] ETH_OTHER      = 16'hFFFF;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  ARP_OP_REQUEST = 8'h01;

   typedef struct packed {
      logic                 op;
      logic [LINK_ID_W-1:0] link;
      logic [31:0]          eip;
      logic [15:0]          eport;
      logic [15:0]          eth;
      logic [31:0]          dip;
      logic [7:0]           proto;
      logic [15:0]          uport;
      logic [7:0]           arpop;
   } request_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_type = REQ_ADD;
   logic [LINK_ID_W-1:0] req_link_id = '0;
   logic [31:0]          req_entry_ip = '0;
   logic [15:0]          req_entry_port = '0;
   logic [15:0]          req_ether_type = '0;
   logic [31:0]          req_dest_ip = '0;
   logic [7:0]           req_ip_proto = '0;
   logic [15:0]          req_udp_dest_port = '0;
   logic [7:0]           req_arp_op_low = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [KIND_W-1:0]    rsp_kind;
   logic [IFACE_W-1:0]   rsp_iface_index;
   logic                 rsp_arp_reply;
   logic                 rsp_last;

   int fail_count;
   int outstanding;
   int beats_checked;
   int items_sent = 0;
   int adds_sent = 0;
   int quiet_cycles = 0;

   // Addresses and ports written to each link, kept only to aim classify requests at hits.
   logic [31:0] shadow_ip   [LINKS_DEF][ENTRIES_DEF];
   logic [15:0] shadow_port [LINKS_DEF][ENTRIES_DEF];
   int          shadow_cnt  [LINKS_DEF] = '{default: 0};

   ingress_packet_classifier #(
      .LINKS            (LINKS_DEF),
      .ENTRIES_PER_LINK (ENTRIES_DEF)
   ) DUT (.*);

   ipc_result_checker #(
      .LINKS            (LINKS_DEF),
      .ENTRIES_PER_LINK (ENTRIES_DEF)
   ) u_checker (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit steady_window();
      return items_sent >= STEADY_LO && items_sent < STEADY_HI;
   endfunction

   // Mostly back to back or short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   function automatic request_type noise();
      request_type r;
      r.op    = 1'($urandom_range(0, 1));
      r.link  = LINK_ID_W'($urandom_range(0, LINKS_DEF - 1));
      r.eip   = $urandom;
      r.eport = 16'($urandom);
      r.eth   = 16'($urandom);
      r.dip   = $urandom;
      r.proto = 8'($urandom);
      r.uport = 16'($urandom);
      r.arpop = 8'($urandom);
      return r;
   endfunction

   function automatic request_type add_req(input int link, input logic [31:0] ip,
                                           input logic [15:0] port);
      request_type r;
      r       = noise();
      r.op    = REQ_ADD;
      r.link  = LINK_ID_W'(link);
      r.eip   = ip;
      r.eport = port;
      return r;
   endfunction

   function automatic request_type classify_req(input int link, input logic [15:0] eth,
                                                input logic [31:0] dip, input logic [7:0] proto,
                                                input logic [15:0] uport,
                                                input logic [7:0] arpop);
      request_type r;
      r       = noise();
      r.op    = REQ_CLASSIFY;
      r.link  = LINK_ID_W'(link);
      r.eth   = eth;
      r.dip   = dip;
      r.proto = proto;
      r.uport = uport;
      r.arpop = arpop;
      return r;
   endfunction

   task automatic offer(input request_type r);
      int gap;
      req_valid         <= 1'b1;
      req_type          <= r.op;
      req_link_id       <= r.link;
      req_entry_ip      <= r.eip;
      req_entry_port    <= r.eport;
      req_ether_type    <= r.eth;
      req_dest_ip       <= r.dip;
      req_ip_proto      <= r.proto;
      req_udp_dest_port <= r.uport;
      req_arp_op_low    <= r.arpop;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      items_sent++;
      if (r.op == REQ_ADD) begin
         adds_sent++;
         if (shadow_cnt[r.link] < ENTRIES_DEF) begin
            shadow_ip[r.link][shadow_cnt[r.link]]   = r.eip;
            shadow_port[r.link][shadow_cnt[r.link]] = r.eport;
            shadow_cnt[r.link]++;
         end
      end
      gap = steady_window() ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin : request_side
      request_type r;
      int          lk;
      int          sel;
      int          pick;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Empty tables: every classify answer is a single drop.
      offer(classify_req(0, ETH_ARP, $urandom, 8'($urandom), 16'($urandom), ARP_OP_REPLY));
      offer(classify_req(1, ETH_IPV4, SUBNET_HOST, PROTO_UDP, TUNNEL_PORT, 8'($urandom)));
      offer(classify_req(2, ETH_IPV4, BCAST_IP, 8'($urandom), 16'($urandom), 8'($urandom)));

      // Fill link 3 completely, with extreme values and a duplicated address.
      offer(add_req(3, 32'h0000_0000, 16'h0000));
      offer(add_req(3, BCAST_IP, 16'hFFFF));
      offer(add_req(3, IP_POOL_BASE, PORT_POOL_BASE));
      offer(add_req(3, IP_POOL_BASE + 32'd1, PORT_POOL_BASE + 16'd1));
      offer(add_req(3, IP_POOL_BASE, 16'hFFFF));
      offer(add_req(3, SUBNET_HOST, TUNNEL_PORT));
      offer(add_req(3, $urandom, 16'($urandom)));
      offer(add_req(3, $urandom, 16'($urandom)));
      offer(add_req(3, $urandom, 16'($urandom)));

      // Broadcast copies over a full table, with and without the reply flag.
      offer(classify_req(3, ETH_ARP, $urandom, 8'($urandom), 16'($urandom), ARP_OP_REPLY));
      offer(classify_req(3, ETH_ARP, $urandom, 8'($urandom), 16'($urandom), ARP_OP_REQUEST));
      offer(classify_req(3, ETH_OTHER, $urandom, PROTO_UDP, 16'($urandom), ARP_OP_REPLY));
      offer(classify_req(3, ETH_IPV4, BCAST_IP, PROTO_UDP, 16'hFFFF, 8'($urandom)));

      // Unicast: worker, interface on port or protocol mismatch, first of two matches, miss.
      offer(classify_req(3, ETH_IPV4, 32'h0000_0000, PROTO_UDP, 16'h0000, 8'($urandom)));
      offer(classify_req(3, ETH_IPV4, IP_POOL_BASE, PROTO_UDP, PORT_POOL_BASE, 8'($urandom)));
      offer(classify_req(3, ETH_IPV4, IP_POOL_BASE, PROTO_UDP, 16'hFFFF, 8'($urandom)));
      offer(classify_req(3, ETH_IPV4, SUBNET_HOST, PROTO_TCP, TUNNEL_PORT, 8'($urandom)));
      offer(classify_req(3, ETH_IPV4, IP_POOL_BASE + 32'd3, PROTO_UDP, TUNNEL_PORT,
                         8'($urandom)));

      // A one-entry table gives a single broadcast copy marked last.
      offer(add_req(0, IP_POOL_BASE + 32'd1, TUNNEL_PORT));
      offer(classify_req(0, ETH_ARP, $urandom, 8'($urandom), 16'($urandom), ARP_OP_REPLY));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         lk     = $urandom_range(0, LINKS_DEF - 1);
         sel    = $urandom_range(0, 99);
         r      = noise();
         r.link = LINK_ID_W'(lk);
         if (sel < 20) begin
            r.op = REQ_ADD;
            if ($urandom_range(0, 1)) r.eip = IP_POOL_BASE + 32'($urandom_range(0, 3));
            if ($urandom_range(0, 1)) r.eport = PORT_POOL_BASE + 16'($urandom_range(0, 1));
         end else begin
            r.op  = REQ_CLASSIFY;
            r.eth = ETH_IPV4;
            if (sel < 55 && shadow_cnt[lk] > 0) begin
               pick  = $urandom_range(0, shadow_cnt[lk] - 1);
               r.dip = shadow_ip[lk][pick];
               if ($urandom_range(0, 9) < 7) r.proto = PROTO_UDP;
               if ($urandom_range(0, 9) < 6) r.uport = shadow_port[lk][pick];
            end else if (sel < 65) begin
               r.dip = IP_POOL_BASE + 32'($urandom_range(0, 7));
            end else if (sel < 85) begin
               r.eth = ETH_ARP;
               case ($urandom_range(0, 2))
                  0: r.arpop = ARP_OP_REPLY;
                  1: r.arpop = ARP_OP_REQUEST;
                  default: ;
               endcase
            end else if (sel < 92) begin
               r.dip = BCAST_IP;
            end else begin
               r.eth = 16'($urandom);
            end
         end
         offer(r);
      end

      req_valid <= 1'b0;
      // The checker's count of awaited results is registered, so it lags the last request beat.
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests (%0d adds, %0d classifies) and %0d result beats.",
               items_sent, adds_sent, items_sent - adds_sent, beats_checked);
      $display("Full and empty tables, broadcast, unicast hits and misses; %0s %0d cycles.",
               "one result stall of", HOLD_CYCLES);
      if (fail_count == 0 && outstanding == 0) begin
         $display("ingress_packet_classifier regression: pass");
      end else begin
         $display("ingress_packet_classifier regression: fail");
      end
      $finish;
   end

   initial begin : result_side
      int  burst;
      int  stall;
      bit  held_off;
      held_off = 1'b0;
      @(posedge clock);
      forever begin
         // One long hold-off while requests keep coming, so the block backs up into its input.
         if (!held_off && items_sent >= HOLD_AT) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held_off = 1'b1;
         end
         burst = $urandom_range(1, 12);
         rsp_ready <= 1'b1;
         repeat (burst) @(posedge clock);
         stall = steady_window() ? 0 : pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no beat on either channel for %0d cycles.", WATCHDOG_LIMIT);
         $display("ingress_packet_classifier regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// File: sim.f
rtl/ipc_pkg.sv
rtl/ipc_table.sv
rtl/ipc_cmp.sv
rtl/ingress_packet_classifier.sv
bench/ipc_result_checker.sv
bench/tb_ingress_packet_classifier.sv
